FILE: rtl/sliding_window_minimum_assert.svh
// Assertion macros used by the checker of the sliding window minimum block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SLIDING_WINDOW_MINIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MINIMUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam int SAMPLE_W = 18;
    localparam int LEN_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [LEN_W-1:0]           len_t;

    typedef struct packed {
        logic    shift;
        sample_t sample;
    } swm_beat_t;

endpackage

FILE: rtl/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell
(
    input  logic               clk,
    input  swm_pkg::swm_beat_t beat,
    input  swm_pkg::sample_t   prev_min,
    output swm_pkg::sample_t   held_min,
    output swm_pkg::sample_t   ahead_min
);

    swm_pkg::sample_t min_reg;
    swm_pkg::sample_t min_next;

    always_comb
    begin
        if ($signed(prev_min) < $signed(beat.sample))
        begin
            min_next = prev_min;
        end
        else
        begin
            min_next = beat.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.shift)
        begin
            min_reg <= min_next;
        end
    end

    assign held_min  = min_reg;
    assign ahead_min = min_next;

endmodule

FILE: rtl/swm_chain.sv
`timescale 1ns / 1ps

module swm_chain
#(
    parameter int DEPTH = 64,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  swm_pkg::swm_beat_t beat,
    input  logic [IDX_W-1:0]   sel,
    output swm_pkg::sample_t   sel_min
);

    // Cell k holds the minimum of the last k+1 samples.
    swm_pkg::sample_t held  [DEPTH];
    swm_pkg::sample_t ahead [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            swm_pkg::sample_t prev;
            if (k == 0)
            begin : g_head
                assign prev = beat.sample;
            end
            else
            begin : g_link
                assign prev = held[k-1];
            end

            swm_cell u_cell
            (
                .clk       (clk),
                .beat      (beat),
                .prev_min  (prev),
                .held_min  (held[k]),
                .ahead_min (ahead[k])
            );
        end
    endgenerate

    assign sel_min = ahead[sel];

endmodule

FILE: rtl/sliding_window_minimum.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_valid, in_stall   start_of_stream, sample
// output    out_valid, out_stall window_min
// config    cfg_wr_en            cfg_wr_data (window_len)
//
// One sample per cycle unless stalled; a result, if any, shows next cycle.
// Every cell compares the new sample with its neighbor in the same cycle.
// Reset clears the fill count, the output valid and sets window_len to 1.
// The input stalls only while a result is held and the output is stalled.

module sliding_window_minimum
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  swm_pkg::len_t        cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 start_of_stream,
    input  swm_pkg::sample_t     sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output swm_pkg::sample_t     window_min
);

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = $clog2(WINDOW_MAX);

    logic [FILL_W-1:0] len_reg;
    logic [IDX_W-1:0]  len_idx_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_base;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] cfg_len;
    logic [IDX_W-1:0]  cfg_idx;
    logic              out_valid_reg;
    logic              out_valid_next;
    swm_pkg::sample_t  min_reg;
    swm_pkg::sample_t  sel_min;
    swm_pkg::swm_beat_t beat;
    logic              accept;
    logic              hit;

    // A length of zero acts as one, and lengths above the depth are clamped.
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_len = FILL_W'(1);
        end
        else if (32'(cfg_wr_data) > WINDOW_MAX)
        begin
            cfg_len = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            cfg_len = FILL_W'(cfg_wr_data);
        end
        cfg_idx = IDX_W'(cfg_len - FILL_W'(1));
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        fill_base = start_of_stream ? '0 : fill_reg;
        if (fill_base < FILL_W'(WINDOW_MAX))
        begin
            fill_next = fill_base + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_base;
        end
        hit = (fill_next >= len_reg);
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = hit;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign beat.shift  = accept;
    assign beat.sample = sample;

    swm_chain
    #(
        .DEPTH (WINDOW_MAX)
    )
    u_chain
    (
        .clk     (clk),
        .beat    (beat),
        .sel     (len_idx_reg),
        .sel_min (sel_min)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= FILL_W'(1);
            len_idx_reg   <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg     <= cfg_len;
                len_idx_reg <= cfg_idx;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            min_reg <= sel_min;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_min = min_reg;

endmodule

FILE: rtl/swm_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_minimum_assert.svh"

module swm_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_wr_en,
    input swm_pkg::len_t    cfg_wr_data,
    input logic             in_valid,
    input logic             in_stall,
    input logic             start_of_stream,
    input swm_pkg::sample_t sample,
    input logic             out_valid,
    input logic             out_stall,
    input swm_pkg::sample_t window_min
);

    swm_pkg::len_t len_seen_reg;
    logic          in_beat;
    logic          len_one;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_seen_reg <= swm_pkg::len_t'(1);
        end
        else if (cfg_wr_en)
        begin
            len_seen_reg <= cfg_wr_data;
        end
    end

    assign in_beat = in_valid && !in_stall;
    assign len_one = (len_seen_reg == swm_pkg::len_t'(0)) ||
                     (len_seen_reg == swm_pkg::len_t'(1));

    `SWM_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid, "input stalled with no result held")
    `SWM_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(window_min), "stalled result changed")
    `SWM_ASSERT_NEXT(a_start_no_result, in_beat && start_of_stream && !len_one, !out_valid, "result after start mark with window longer than one")
    `SWM_ASSERT_NEXT(a_len_one_echo, in_beat && len_one, out_valid && (window_min == $past(sample)), "window of one did not echo the sample")

endmodule

bind sliding_window_minimum swm_checker u_swm_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .start_of_stream (start_of_stream),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .window_min      (window_min)
);

FILE: verif/sliding_window_minimum_tb.sv
`timescale 1ns / 1ps

module sliding_window_minimum_tb;

    localparam int WINDOW_MAX = 64;
    localparam swm_pkg::sample_t SAMPLE_LOW  = -18'sd131072;
    localparam swm_pkg::sample_t SAMPLE_HIGH = 18'sd131071;
    localparam int RANDOM_BEATS = 750;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    swm_pkg::len_t cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic start_of_stream = 1'b0;
    swm_pkg::sample_t sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    swm_pkg::sample_t window_min;

    swm_pkg::swm_beat_t pending_beats[$];
    swm_pkg::sample_t expected_mins[$];
    swm_pkg::swm_beat_t next_beat;

    swm_pkg::sample_t history[WINDOW_MAX];
    int fill_count = 0;
    int write_slot = 0;
    swm_pkg::len_t window_setting = 7'd1;

    int beats_queued = 0;
    int beats_taken = 0;
    int mins_checked = 0;
    int mismatches = 0;
    int settings_used = 0;
    logic no_gaps = 1'b0;

    sliding_window_minimum #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .start_of_stream(start_of_stream),
        .sample(sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .window_min(window_min)
    );

    always #5 clk = ~clk;

    function automatic int clamp_len(input swm_pkg::len_t len);
        if (len == 0)
            return 1;
        if (len > WINDOW_MAX)
            return WINDOW_MAX;
        return len;
    endfunction

    task automatic predict_window_min(input logic sos, input swm_pkg::sample_t value);
        int span;
        swm_pkg::sample_t best;
        if (sos)
            fill_count = 0;
        history[write_slot] = value;
        write_slot = (write_slot + 1) % WINDOW_MAX;
        if (fill_count < WINDOW_MAX)
            fill_count++;
        span = clamp_len(window_setting);
        if (fill_count >= span)
        begin
            best = value;
            for (int k = 1; k < span; k++)
            begin
                if (history[(write_slot + WINDOW_MAX - 1 - k) % WINDOW_MAX] < best)
                    best = history[(write_slot + WINDOW_MAX - 1 - k) % WINDOW_MAX];
            end
            expected_mins = {expected_mins, best};
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            start_of_stream <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_window_min(start_of_stream, sample);
                beats_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 25))
                begin
                    next_beat = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    start_of_stream <= next_beat.shift;
                    sample <= next_beat.sample;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_mins.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("ERROR: window minimum %0d arrived with none expected",
                                 window_min);
                    mismatches++;
                end
                else
                begin
                    if (window_min !== expected_mins[0])
                    begin
                        if (mismatches < 10)
                            $display("ERROR: window_min expected %0d, got %0d",
                                     expected_mins[0], window_min);
                        mismatches++;
                    end
                    void'(expected_mins.pop_front());
                    mins_checked++;
                end
            end
            out_stall <= !no_gaps && ($urandom_range(0, 99) < 25);
        end
    end

    task automatic queue_beat(input logic sos, input swm_pkg::sample_t value);
        swm_pkg::swm_beat_t b;
        b.shift = sos;
        b.sample = value;
        pending_beats = {pending_beats, b};
        beats_queued++;
    endtask

    function automatic swm_pkg::sample_t pick_sample();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 10)
        begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_LOW;
                1: return SAMPLE_HIGH;
                2: return '0;
                default: return -18'sd1;
            endcase
        end
        if (mode < 30)
            return swm_pkg::sample_t'($signed($urandom_range(0, 16)) - 8);
        return swm_pkg::sample_t'($urandom);
    endfunction

    task automatic write_window_len(input swm_pkg::len_t len);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        window_setting = len;
        settings_used++;
    endtask

    task automatic drain();
        while (beats_taken != beats_queued || expected_mins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int seq_count;
        int run_len;
        int pick;
        swm_pkg::len_t len;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of the window length is one.
        queue_beat(1'b1, SAMPLE_LOW);
        queue_beat(1'b0, SAMPLE_HIGH);
        queue_beat(1'b0, '0);
        queue_beat(1'b1, -18'sd1);
        queue_beat(1'b0, 18'sd1);
        drain();

        write_window_len(7'd0);
        queue_beat(1'b1, 18'sd5);
        queue_beat(1'b0, -18'sd5);
        queue_beat(1'b1, SAMPLE_HIGH);
        drain();

        // A start mark on every beat yields nothing for a window of three.
        write_window_len(7'd3);
        queue_beat(1'b1, 18'sd11);
        queue_beat(1'b1, -18'sd11);
        queue_beat(1'b1, SAMPLE_LOW);
        queue_beat(1'b1, 18'sd4);
        queue_beat(1'b0, 18'sd7);
        queue_beat(1'b0, -18'sd2);
        queue_beat(1'b0, 18'sd9);
        drain();

        // The sequence continues across the following length changes.
        write_window_len(7'd2);
        queue_beat(1'b0, 18'sd4);
        queue_beat(1'b0, SAMPLE_LOW);
        queue_beat(1'b0, SAMPLE_HIGH);
        drain();
        write_window_len(7'd5);
        queue_beat(1'b0, 18'sd100);
        queue_beat(1'b0, 18'sd50);
        drain();

        phase = 0;
        while (beats_queued < RANDOM_BEATS + 20)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: len = 7'd0;
                1: len = 7'd1;
                2: len = 7'd64;
                3: len = swm_pkg::len_t'($urandom_range(65, 126));
                4: len = 7'd127;
                default: len = swm_pkg::len_t'($urandom_range(2, 12));
            endcase
            write_window_len(len);
            no_gaps = (phase == 4);
            seq_count = $urandom_range(1, 3);
            for (int s = 0; s < seq_count; s++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    run_len = clamp_len(len) + $urandom_range(0, 24);
                    for (int i = 0; i < run_len; i++)
                        queue_beat(i == 0, pick_sample());
                end
                else if (pick < 90)
                begin
                    for (int i = 0; i < 12; i++)
                        queue_beat($urandom_range(0, 99) < 30, pick_sample());
                end
                else
                begin
                    for (int i = 0; i < 8; i++)
                        queue_beat(1'b0, pick_sample());
                end
            end
            drain();
            phase++;
        end
        no_gaps = 1'b0;

        $display("Sent %0d samples under %0d window length settings.",
                 beats_taken, settings_used);
        $display("Compared %0d window minimums, %0d mismatches.", mins_checked, mismatches);
        if (mismatches == 0 && expected_mins.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d samples taken of %0d.", beats_taken, beats_queued);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_chain.sv
rtl/sliding_window_minimum.sv
rtl/swm_checker.sv
verif/sliding_window_minimum_tb.sv
